// ----- rtl/smes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smes_pkg
// Shared types and fixed constants of the sparse matrix entry store.
// ----------------------------------------------------------------------------
package smes_pkg;

  localparam int DIM_W    = 11;  // coordinate and dimension register width
  localparam int VAL_W    = 32;  // cell value width
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

endpackage

// ----- rtl/smes_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smes_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module smes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sparse_matrix_entry_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_matrix_entry_store
// Table of nonzero matrix cells with insert, remove, update and value search.
// ----------------------------------------------------------------------------
// Every entry (valid, zero-based row, column, value) lives in one RAM word.
// A command walks the whole table through the RAM read port, one entry per
// cycle, gathering the coordinate match, the lowest free entry and the best
// row-major search hit, then commits at most one RAM write and loads the
// result register. The walk reads every entry, then drains the read latency
// (S_SCAN, S_DRAIN) and commits in S_FIN, where a stalled result holds it;
// the next item is taken in the cycle after the commit, even while the result
// is still stalled, and no new command is taken before the commit.
// After reset a clearing pass marks every entry free; no item is taken
// during it, register writes are.
// ----------------------------------------------------------------------------
module sparse_matrix_entry_store
  import smes_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int MAX_DIM  = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  // command channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [DIM_W-1:0]     in_cell_row,
  input  logic [DIM_W-1:0]     in_cell_col,
  input  logic signed [VAL_W-1:0] in_cell_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic                 out_found,
  output logic [DIM_W-1:0]     out_found_row,
  output logic [DIM_W-1:0]     out_found_col,
  output logic                 out_zero_note
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CMP_W = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
  localparam int MW    = 1 + 2 * EW + VAL_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] rows_r, cols_r;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic             rd_pend_r;
  logic [AW-1:0]    rd_idx_r;

  // item under work
  cmd_t             cmd_r;
  logic [EW-1:0]    row0_r, col0_r;
  logic [VAL_W-1:0] val_r;
  logic             coord_ok_r;

  // scan results
  logic             hit_r, free_r, found_r;
  logic [AW-1:0]    hit_idx_r, free_idx_r;
  logic [EW-1:0]    best_row_r, best_col_r;

  // result register
  logic             out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic             out_found_r;
  logic [DIM_W-1:0] out_found_row_r, out_found_col_r;
  logic             out_zero_note_r;

  // memory
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [MW-1:0]    mem_wdata, mem_rdata;

  logic             d_valid;
  logic [EW-1:0]    d_row, d_col;
  logic [VAL_W-1:0] d_val;

  logic [CMP_W-1:0] row_lim, col_lim, in_row_ext, in_col_ext, row_m1, col_m1;
  logic             in_xfer, commit, in_coord_ok;
  logic             d_coord_hit, d_search_hit, d_better;
  logic [STAT_W-1:0] fin_status;
  logic             fin_write;

  smes_ram #(
    .WIDTH (MW),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt_r),
    .rdata (mem_rdata)
  );

  assign d_valid = mem_rdata[MW-1];
  assign d_row   = mem_rdata[MW-2 -: EW];
  assign d_col   = mem_rdata[VAL_W+EW-1 -: EW];
  assign d_val   = mem_rdata[VAL_W-1:0];

  // dimensions in use saturate at MAX_DIM
  assign row_lim = (CMP_W'(rows_r) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(rows_r);
  assign col_lim = (CMP_W'(cols_r) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(cols_r);

  assign in_row_ext  = CMP_W'(in_cell_row);
  assign in_col_ext  = CMP_W'(in_cell_col);
  assign row_m1      = in_row_ext - CMP_W'(1);
  assign col_m1      = in_col_ext - CMP_W'(1);
  assign in_coord_ok = (in_cell_row != '0) && (in_row_ext <= row_lim) &&
                       (in_cell_col != '0) && (in_col_ext <= col_lim);

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign commit   = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // per-entry compare on the word read back
  assign d_coord_hit  = d_valid && (d_row == row0_r) && (d_col == col0_r);
  assign d_search_hit = d_valid && (d_val == val_r) &&
                        (CMP_W'(d_row) < row_lim) && (CMP_W'(d_col) < col_lim);
  assign d_better     = !found_r || ({d_row, d_col} < {best_row_r, best_col_r});

  // decision at the end of the walk
  always_comb begin
    fin_status = ST_IGNORED;
    fin_write  = 1'b0;
    case (cmd_r)
      CMD_SEARCH: fin_status = ST_DONE;
      CMD_INSERT: begin
        if (coord_ok_r && (val_r != '0) && !hit_r) begin
          fin_status = free_r ? ST_DONE : ST_FULL;
          fin_write  = free_r;
        end
      end
      CMD_REMOVE, CMD_UPDATE: begin
        if (coord_ok_r && hit_r) begin
          fin_status = ST_DONE;
          fin_write  = 1'b1;
        end
      end
      default: fin_status = ST_IGNORED;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (commit && fin_write) begin
      mem_we    = 1'b1;
      mem_waddr = (cmd_r == CMD_INSERT) ? free_idx_r : hit_idx_r;
      mem_wdata = {(cmd_r != CMD_REMOVE), row0_r, col0_r, val_r};
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_xfer) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      rows_r      <= DIM_RESET;
      cols_r      <= DIM_RESET;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= (state_r == S_SCAN);
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) begin
          rows_r <= cfg_wdata;
        end else begin
          cols_r <= cfg_wdata;
        end
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        hit_r   <= 1'b0;
        free_r  <= 1'b0;
        found_r <= 1'b0;
      end else if (rd_pend_r) begin
        if (d_coord_hit && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!d_valid && !free_r) begin
          free_r <= 1'b1;
        end
        if (d_search_hit) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (in_xfer) begin
      cmd_r      <= cmd_t'(in_command);
      row0_r     <= row_m1[EW-1:0];
      col0_r     <= col_m1[EW-1:0];
      val_r      <= in_cell_value;
      coord_ok_r <= in_coord_ok;
    end
    if (rd_pend_r) begin
      if (d_coord_hit && !hit_r) begin
        hit_idx_r <= rd_idx_r;
      end
      if (!d_valid && !free_r) begin
        free_idx_r <= rd_idx_r;
      end
      // keep the lowest row, then the lowest column
      if (d_search_hit && d_better) begin
        best_row_r <= d_row;
        best_col_r <= d_col;
      end
    end
    if (commit) begin
      out_status_r    <= fin_status;
      out_found_r     <= (cmd_r == CMD_SEARCH) && found_r;
      out_found_row_r <= ((cmd_r == CMD_SEARCH) && found_r) ?
                         DIM_W'(CMP_W'(best_row_r) + CMP_W'(1)) : '0;
      out_found_col_r <= ((cmd_r == CMD_SEARCH) && found_r) ?
                         DIM_W'(CMP_W'(best_col_r) + CMP_W'(1)) : '0;
      out_zero_note_r <= (cmd_r == CMD_SEARCH) && (val_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_found_row = out_found_row_r;
  assign out_found_col = out_found_col_r;
  assign out_zero_note = out_zero_note_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR) || (state_r == S_FIN))
    else $error("entry RAM written outside clear pass or commit");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result appeared without a commit");

  a_insert_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && fin_write && (cmd_r == CMD_INSERT)) |-> (!hit_r && free_r))
    else $error("insert committed over a present cell or into a full table");

  a_found_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |->
      (out_found_row_r != '0) && (out_found_col_r != '0) && (out_status_r == ST_DONE))
    else $error("search hit reported with a zero coordinate");

endmodule
